### rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64 stream decoder
// Holds the status codes, the character classes, the command word that the
// front end hands to the back end, and the character classifier.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Result status codes.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_END   = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // Default depth of the command queue between front and back end.
    localparam int CMD_DEPTH = 4;

    // Offsets of the alphabet ranges in six-bit value space.
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] PLUS_VAL   = 6'd62;
    localparam logic [5:0] SLASH_VAL  = 6'd63;

    typedef enum logic [1:0] {
        CC_ALPHA,
        CC_PAD,
        CC_SPACE,
        CC_BAD
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic [5:0]  val;
    } t_char_info;

    // One command for the back end: a single status beat, or a decoded group
    // whose bytes go out most significant first, up to index last_idx.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  last_idx;
        logic [23:0] word;
    } t_cmd;

    // Maps a character byte to its class and six-bit value. A pad reads as 0.
    function automatic t_char_info classify(input logic [7:0] c);
        t_char_info info;
        logic [7:0] off;
        info.cls = CC_BAD;
        info.val = 6'd0;
        off      = 8'd0;
        if (c >= "A" && c <= "Z") begin
            off      = c - 8'd65;
            info.cls = CC_ALPHA;
            info.val = off[5:0];
        end else if (c >= "a" && c <= "z") begin
            off      = c - 8'd97 + LOWER_BASE;
            info.cls = CC_ALPHA;
            info.val = off[5:0];
        end else if (c >= "0" && c <= "9") begin
            off      = c - 8'd48 + DIGIT_BASE;
            info.cls = CC_ALPHA;
            info.val = off[5:0];
        end else if (c == "+") begin
            info.cls = CC_ALPHA;
            info.val = PLUS_VAL;
        end else if (c == "/") begin
            info.cls = CC_ALPHA;
            info.val = SLASH_VAL;
        end else if (c == "=") begin
            info.cls = CC_PAD;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0C || c == 8'h0B ||
                     c == 8'h0A || c == 8'h0D) begin
            info.cls = CC_SPACE;
        end
        return info;
    endfunction

endpackage

### rtl/core/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: character classifier and group assembler
// Classifies each accepted character, collects four-character groups and
// issues one command per beat that causes results.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char_in,
    input  logic           i_is_end,
    output logic           o_cmd_valid,
    output b64d_pkg::t_cmd o_cmd
);

    logic [1:0] r_group_count, n_group_count;
    logic [5:0] r_held [3];
    logic [5:0] n_held [3];
    logic       r_third_pad, n_third_pad;

    b64d_pkg::t_char_info info;

    assign info = b64d_pkg::classify(i_char_in);

    // Decide the command and the next group state for the current beat.
    always_comb begin
        n_group_count = r_group_count;
        n_held        = r_held;
        n_third_pad   = r_third_pad;
        o_cmd_valid   = 1'b0;
        o_cmd.status  = b64d_pkg::ST_DATA;
        o_cmd.last_idx = 2'd0;
        o_cmd.word    = 24'd0;
        if (i_accept) begin
            priority if (i_is_end) begin
                o_cmd_valid  = 1'b1;
                o_cmd.status = (r_group_count != 2'd0) ? b64d_pkg::ST_TRUNC
                                                       : b64d_pkg::ST_END;
                n_group_count = 2'd0;
                n_held        = '{default: 6'd0};
                n_third_pad   = 1'b0;
            end else if (info.cls == b64d_pkg::CC_SPACE) begin
                // Whitespace leaves everything as it is.
            end else if (info.cls == b64d_pkg::CC_BAD ||
                         (info.cls == b64d_pkg::CC_PAD && r_group_count < 2'd2)) begin
                o_cmd_valid   = 1'b1;
                o_cmd.status  = b64d_pkg::ST_BAD;
                n_group_count = 2'd0;
                n_held        = '{default: 6'd0};
                n_third_pad   = 1'b0;
            end else if (r_group_count != 2'd3) begin
                n_held[r_group_count] = info.val;
                if (info.cls == b64d_pkg::CC_PAD && r_group_count == 2'd2) begin
                    n_third_pad = 1'b1;
                end
                n_group_count = r_group_count + 2'd1;
            end else begin
                // Fourth character: bytes past the group's length are never
                // sent, so the packed word needs no masking.
                o_cmd_valid = 1'b1;
                o_cmd.word  = {r_held[0], r_held[1], r_held[2], info.val};
                if (r_third_pad) begin
                    o_cmd.last_idx = 2'd0;
                end else if (info.cls == b64d_pkg::CC_PAD) begin
                    o_cmd.last_idx = 2'd1;
                end else begin
                    o_cmd.last_idx = 2'd2;
                end
                n_group_count = 2'd0;
                n_held        = '{default: 6'd0};
                n_third_pad   = 1'b0;
            end
        end
    end

    // Group state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= 2'd0;
            r_held        <= '{default: 6'd0};
            r_third_pad   <= 1'b0;
        end else begin
            r_group_count <= n_group_count;
            r_held        <= n_held;
            r_third_pad   <= n_third_pad;
        end
    end

endmodule

### rtl/core/b64d_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_cmd_fifo: command queue between front and back end
// A small register queue; the head entry is visible while it is not empty.
// ----------------------------------------------------------------------------
module b64d_cmd_fifo #(
    parameter int DEPTH = b64d_pkg::CMD_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  b64d_pkg::t_cmd i_wr_cmd,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output b64d_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    b64d_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CNT_ONE;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

endmodule

### rtl/core/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: result sequencer
// Holds one command and sends its result beats one per pop, loading the next
// command from the queue as the last beat leaves.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  b64d_pkg::t_cmd i_head,
    output logic           o_head_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     o_byte_out,
    output logic [1:0]     o_status,
    output logic           o_last
);

    logic           r_valid;
    logic [1:0]     r_idx;
    b64d_pkg::t_cmd r_cmd;
    logic           beat_done, finish, load;
    logic [7:0]     sel_byte;

    assign beat_done  = pop && r_valid;
    assign finish     = beat_done && (r_idx == r_cmd.last_idx);
    assign load       = !r_valid || finish;
    assign o_head_pop = load && i_head_valid;

    // Pick the byte of the group for the current beat.
    always_comb begin
        unique case (r_idx)
            2'd0:    sel_byte = r_cmd.word[23:16];
            2'd1:    sel_byte = r_cmd.word[15:8];
            default: sel_byte = r_cmd.word[7:0];
        endcase
    end

    assign empty      = !r_valid;
    assign o_status   = r_cmd.status;
    assign o_byte_out = (r_cmd.status == b64d_pkg::ST_DATA) ? sel_byte : 8'd0;
    assign o_last     = (r_idx == r_cmd.last_idx);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= i_head_valid;
            r_idx   <= 2'd0;
        end else if (beat_done) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    // Command payload.
    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_cmd <= i_head;
        end
    end

    // The beat index never runs past the command's last beat.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_cmd.last_idx))
        else $error("beat index past last beat");

    // Status commands are exactly one beat long.
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd.status != b64d_pkg::ST_DATA) |-> (r_cmd.last_idx == 2'd0))
        else $error("status command longer than one beat");

    // Taking the last beat with nothing queued leaves the output empty.
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last && !i_head_valid) |=> empty)
        else $error("output not empty after draining");

    // A stalled beat keeps its index.
    a_hold_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !pop) |=> $stable(r_idx))
        else $error("beat index moved without pop");

endmodule

### rtl/core/base64_stream_decoder.sv
// Path: an accepted beat's command is written into the command queue, then
// loaded into the back end's command register when the back end is free.
// Throughput: one character per cycle while not full; a group's bytes leave
// one per cycle on pop from the command register, buffered by the command queue.
// Reset: synchronous, active low; clears the group state, queue pointers and
// output valid. No clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder: base64 text to byte stream decoder
// Front end classifies characters and assembles groups, a command queue
// decouples it from the back end that sends the result beats.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int CMD_DEPTH = b64d_pkg::CMD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_in,
    input  logic       i_is_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_byte_out,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic           accept;
    logic           cmd_valid;
    b64d_pkg::t_cmd cmd;
    logic           q_empty;
    b64d_pkg::t_cmd q_head;
    logic           q_pop;

    assign accept = push && !full;

    // Front end: classification and group assembly.
    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_in   (i_char_in),
        .i_is_end    (i_is_end),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Command queue between the two halves.
    b64d_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_valid),
        .i_wr_cmd (cmd),
        .i_rd     (q_pop),
        .o_full   (full),
        .o_empty  (q_empty),
        .o_head   (q_head)
    );

    // Back end: result beats.
    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_head_pop   (q_pop),
        .pop          (pop),
        .empty        (empty),
        .o_byte_out   (o_byte_out),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the base64 stream decoder
// Drives base64 text through the push/full side and pops decoded beats with
// random gaps on both sides. A local decoder model predicts every beat, and
// each popped beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RUN_LIMIT    = 200000;
    localparam int IDLE_PERCENT = 18;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } t_beat;

    // DUT connections, all inputs known from time zero.
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic [7:0] i_char_in = 8'd0;
    logic       i_is_end  = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_byte_out;
    logic [1:0] o_status;
    logic       o_last;

    // Decoder model state.
    logic [1:0] grp_cnt   = 2'd0;
    logic [5:0] held [3]  = '{default: 6'd0};
    logic       third_pad = 1'b0;

    t_beat expected_beats [$];
    int    err_count   = 0;
    int    cycle_count = 0;
    int    chars_sent  = 0;
    bit    idle_en     = 1'b1;

    base64_stream_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_char_in  (i_char_in),
        .i_is_end   (i_is_end),
        .empty      (empty),
        .pop        (pop),
        .o_byte_out (o_byte_out),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Hard stop in case the decoder hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Counts an error and prints the first few.
    function automatic void note_error(input string msg);
        if (err_count < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        err_count++;
    endfunction

    // Appends one predicted beat at the tail of the expected queue.
    function automatic void queue_beat(input logic [7:0] data, input logic [1:0] status,
                                       input logic last);
        t_beat b;
        b.data   = data;
        b.status = status;
        b.last   = last;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // Class and six-bit value of one character byte.
    function automatic b64d_pkg::t_char_info lookup_sextet(input logic [7:0] c);
        b64d_pkg::t_char_info info;
        info.cls = b64d_pkg::CC_BAD;
        info.val = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            info.cls = b64d_pkg::CC_ALPHA;
            info.val = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            info.cls = b64d_pkg::CC_ALPHA;
            info.val = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            info.cls = b64d_pkg::CC_ALPHA;
            info.val = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            info.cls = b64d_pkg::CC_ALPHA;
            info.val = 6'd62;
        end else if (c == 8'h2F) begin
            info.cls = b64d_pkg::CC_ALPHA;
            info.val = 6'd63;
        end else if (c == 8'h3D) begin
            info.cls = b64d_pkg::CC_PAD;
        end else if (c == 8'h20 || c == 8'h09 || c == 8'h0C || c == 8'h0B ||
                     c == 8'h0A || c == 8'h0D) begin
            info.cls = b64d_pkg::CC_SPACE;
        end
        return info;
    endfunction

    function automatic void clear_group();
        grp_cnt   = 2'd0;
        held      = '{default: 6'd0};
        third_pad = 1'b0;
    endfunction

    // Advances the decoder model by one accepted beat and queues its results.
    function automatic void predict_decode(input logic [7:0] c, input logic e);
        b64d_pkg::t_char_info info;
        logic [23:0]          word;
        int                   nbytes;
        info = lookup_sextet(c);
        if (e) begin
            if (grp_cnt != 2'd0) begin
                clear_group();
                queue_beat(8'd0, b64d_pkg::ST_TRUNC, 1'b1);
            end else begin
                queue_beat(8'd0, b64d_pkg::ST_END, 1'b1);
            end
        end else if (info.cls == b64d_pkg::CC_SPACE) begin
            // Whitespace is dropped without a trace.
        end else if (info.cls == b64d_pkg::CC_BAD ||
                     (info.cls == b64d_pkg::CC_PAD && grp_cnt < 2'd2)) begin
            clear_group();
            queue_beat(8'd0, b64d_pkg::ST_BAD, 1'b1);
        end else if (grp_cnt < 2'd3) begin
            held[grp_cnt] = (info.cls == b64d_pkg::CC_PAD) ? 6'd0 : info.val;
            if (info.cls == b64d_pkg::CC_PAD && grp_cnt == 2'd2) begin
                third_pad = 1'b1;
            end
            grp_cnt = grp_cnt + 2'd1;
        end else begin
            // The fourth character closes the group.
            if (third_pad) begin
                nbytes = 1;
            end else if (info.cls == b64d_pkg::CC_PAD) begin
                nbytes = 2;
            end else begin
                nbytes = 3;
            end
            word = {held[0], held[1], (nbytes >= 2) ? held[2] : 6'd0,
                    (nbytes == 3) ? info.val : 6'd0};
            for (int i = 0; i < nbytes; i++) begin
                queue_beat(word[23 - 8 * i -: 8], b64d_pkg::ST_DATA, (i == nbytes - 1));
            end
            clear_group();
        end
    endfunction

    // Sends one beat, with optional idle cycles ahead of it.
    task automatic send_item(input logic [7:0] c, input logic e);
        b64d_pkg::t_char_info info;
        while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge i_clk);
            push <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_char_in <= c;
        i_is_end  <= e;
        do begin
            @(posedge i_clk);
        end while (full);
        predict_decode(c, e);
        info = lookup_sextet(c);
        if (e || info.cls != b64d_pkg::CC_SPACE) begin
            chars_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) begin
            return 8'(8'h41 + idx);
        end else if (idx < 52) begin
            return 8'(8'h61 + idx - 26);
        end else if (idx < 62) begin
            return 8'(8'h30 + idx - 52);
        end else if (idx == 62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    function automatic logic [7:0] space_char();
        logic [7:0] spaces [6] = '{8'h20, 8'h09, 8'h0C, 8'h0B, 8'h0A, 8'h0D};
        return spaces[$urandom_range(0, 5)];
    endfunction

    // Sends one character, sometimes preceded by whitespace.
    task automatic send_spaced(input logic [7:0] c);
        if ($urandom_range(0, 99) < 12) begin
            send_item(space_char(), 1'b0);
        end
        send_item(c, 1'b0);
    endtask

    // One random piece of text: mostly well-formed groups, some broken ones.
    task automatic send_random_group();
        int pick;
        int shape;
        int nchars;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // Any byte at all.
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 11) begin
            // Pad in the first or second position.
            nchars = $urandom_range(0, 1);
            for (int i = 0; i < nchars; i++) begin
                send_spaced(alpha_char($urandom_range(0, 63)));
            end
            send_spaced(8'h3D);
        end else if (pick < 16) begin
            // Group cut short by the end marker.
            nchars = $urandom_range(1, 3);
            for (int i = 0; i < nchars; i++) begin
                send_spaced(alpha_char($urandom_range(0, 63)));
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 22) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            shape = $urandom_range(0, 3);
            send_spaced(alpha_char($urandom_range(0, 63)));
            send_spaced(alpha_char($urandom_range(0, 63)));
            if (shape == 3) begin
                send_spaced(8'h3D);
                send_spaced($urandom_range(0, 1) ? 8'h3D : alpha_char($urandom_range(0, 63)));
            end else begin
                send_spaced(alpha_char($urandom_range(0, 63)));
                send_spaced(shape == 2 ? 8'h3D : alpha_char($urandom_range(0, 63)));
            end
        end
    endtask

    // Full three-byte groups, extreme sextet values, clean end.
    task automatic test_full_groups();
        send_text("TWFu");
        send_text("/+9z");
        send_text("AAAA");
        send_item(8'h00, 1'b1);
    endtask

    // Pads in the fourth and third positions, and after a third pad.
    task automatic test_padding();
        send_text("TWE=");
        send_text("TQ==");
        send_text("TQ=A");
    endtask

    // Whitespace, early pads, bad bytes, truncated group.
    task automatic test_errors();
        send_text("\t =");
        send_text("T=");
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("Ab\n");
        send_item(8'hFF, 1'b1);
    endtask

    // Random text with no idle cycles on either side.
    task automatic test_back_to_back(input int target);
        idle_en = 1'b0;
        target  = chars_sent + target;
        while (chars_sent < target) begin
            send_random_group();
        end
        idle_en = 1'b1;
    endtask

    // Random text with random gaps on both sides.
    task automatic test_random_stream(input int target);
        target = chars_sent + target;
        while (chars_sent < target) begin
            send_random_group();
        end
    endtask

    // Lets every expected beat come out, then a few more cycles.
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random pop stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !idle_en || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Compares each popped beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && pop && !empty) begin
            if (expected_beats.size() == 0) begin
                note_error($sformatf("unexpected beat byte=%h status=%0d last=%b",
                                     o_byte_out, o_status, o_last));
            end else begin
                want = expected_beats.pop_front();
                if (o_byte_out !== want.data || o_status !== want.status ||
                    o_last !== want.last) begin
                    note_error($sformatf(
                        "mismatch: expected byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
                        want.data, want.status, want.last, o_byte_out, o_status, o_last));
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_groups();
        test_padding();
        test_errors();
        test_back_to_back(50);
        test_random_stream(120);
        drain();

        if (expected_beats.size() != 0) begin
            note_error($sformatf("%0d expected beats never arrived", expected_beats.size()));
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
